>>> rtl/nht_pkg.sv
// Shared types and constants for the next-hop table block.
// Used by every module in rtl/; depends on nothing else.
package nht_pkg;

    localparam int ID_W            = 7;
    localparam int DEFAULT_ENTRIES = 128;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_PURGE  = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t         op;
        logic [ID_W-1:0] id;
        logic            in_range;
        logic [ID_W-1:0] hop;
    } cmd_t;

    function automatic logic id_in_range(input logic [ID_W-1:0] id, input int entries);
        logic [ID_W+1:0] lim;
        lim = (ID_W + 2)'(entries);
        return {2'b00, id} < lim;
    endfunction

endpackage

>>> rtl/nht_front.sv
// Front end: accepts command items and classifies them for the back end.
// Depends on nht_pkg.
module nht_front
    import nht_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic            start,
    input  logic            queue_full,
    input  logic [1:0]      opcode,
    input  logic [ID_W-1:0] target_id,
    input  logic [ID_W-1:0] hop_in,
    output logic            busy,
    output logic            push,
    output cmd_t            cmd
);

    assign busy         = queue_full;
    assign push         = start && !queue_full;
    assign cmd.op       = opcode_t'(opcode);
    assign cmd.id       = target_id;
    assign cmd.in_range = id_in_range(target_id, TABLE_ENTRIES);
    assign cmd.hop      = hop_in;

endmodule

>>> rtl/nht_queue.sv
// Short command queue between the front end and the back end.
// Depends on nht_pkg.
module nht_queue
    import nht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic avail,
    output cmd_t head
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign avail = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/nht_back.sv
// Back end: holds the table (valid flops plus hop memory) and executes commands.
// Purge runs a sweep over all entries. Depends on nht_pkg.
module nht_back
    import nht_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  cmd_t            head,
    input  logic [ID_W-1:0] self_id,
    output logic            pop,
    output logic            sweeping,
    output logic            result_valid,
    output logic            found,
    output logic [ID_W-1:0] hop_out
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [ID_W-1:0]          hop_mem [TABLE_ENTRIES];
    logic [ID_W-1:0]          rd_data_reg;
    logic [IDX_W-1:0]         sweep_idx_reg;
    logic [IDX_W-1:0]         chk_idx_reg;
    logic                     chk_valid_reg;
    logic [ID_W-1:0]          purge_id_reg;
    logic                     look_pend_reg;
    logic                     look_hit_reg;

    logic [ID_W+1:0]  cmd_ext;
    logic [ID_W+1:0]  self_ext;
    logic [IDX_W-1:0] cmd_idx;
    logic [IDX_W-1:0] self_idx;
    logic             self_in_range;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             sweep_last;

    assign cmd_ext       = {2'b00, head.id};
    assign self_ext      = {2'b00, self_id};
    assign cmd_idx       = cmd_ext[IDX_W-1:0];
    assign self_idx      = self_ext[IDX_W-1:0];
    assign self_in_range = id_in_range(self_id, TABLE_ENTRIES);
    assign sweep_last    = sweep_idx_reg == IDX_W'(TABLE_ENTRIES - 1);

    assign pop          = (state_reg == ST_IDLE) && avail;
    assign sweeping     = state_reg != ST_IDLE;
    assign result_valid = look_pend_reg;
    assign found        = look_hit_reg;
    assign hop_out      = look_hit_reg ? rd_data_reg : '0;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = cmd_idx;
        if (state_reg == ST_SWEEP)
        begin
            rd_en   = 1'b1;
            rd_addr = sweep_idx_reg;
        end
        else if (pop && head.op == OP_LOOKUP)
        begin
            rd_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && head.op == OP_PURGE)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            sweep_idx_reg <= '0;
            chk_valid_reg <= 1'b0;
            look_pend_reg <= 1'b0;
            look_hit_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= state_reg == ST_SWEEP;
            look_pend_reg <= pop && head.op == OP_LOOKUP;
            if (state_reg == ST_SWEEP)
            begin
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end
            else
            begin
                sweep_idx_reg <= '0;
            end
            if (chk_valid_reg && rd_data_reg == purge_id_reg)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end
            if (pop)
            begin
                unique case (head.op)
                    OP_INSERT:
                    begin
                        if (head.in_range)
                        begin
                            valid_reg[cmd_idx] <= 1'b1;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        look_hit_reg <= head.in_range && valid_reg[cmd_idx];
                    end
                    OP_PURGE:
                    begin
                        if (head.in_range)
                        begin
                            valid_reg[cmd_idx] <= 1'b0;
                        end
                    end
                    OP_CLEAR:
                    begin
                        valid_reg <= self_in_range ? (TABLE_ENTRIES'(1) << self_idx) : '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= sweep_idx_reg;
        if (pop && head.op == OP_PURGE)
        begin
            purge_id_reg <= head.id;
        end
        if (rd_en)
        begin
            rd_data_reg <= hop_mem[rd_addr];
        end
        if (pop && head.op == OP_INSERT && head.in_range)
        begin
            hop_mem[cmd_idx] <= head.hop;
        end
        else if (pop && head.op == OP_CLEAR && self_in_range)
        begin
            hop_mem[self_idx] <= self_id;
        end
    end

endmodule

>>> rtl/next_hop_table_with_purge_top.sv
// Top level of the next-hop forwarding table with purge.
// Instantiates nht_front, nht_queue and nht_back; depends on nht_pkg.
//
// Usage: a command item is taken at a rising edge where start is high and
// busy is low. opcode selects insert, lookup, purge of a leaving node, or
// clear. Only lookup gives a result: result_valid is high for one cycle
// with found and hop_out, and the receiver must take it then.
// cfg_ready is always high. The user must write the self id register over
// cfg_valid/cfg_data only while the block is idle; this is not enforced.
// Items pass through a two-entry queue to the execution unit. Insert, lookup
// and clear are each executed as soon as they reach the head of the queue,
// so one item per cycle is sustained for them while no purge is in progress.
// A lookup result is registered after the item is popped. A purge holds the
// execution unit while it sweeps the hop memory, one entry per cycle through
// its single read port; busy rises once the queue fills.
// Reset empties every table entry at once and sets the self id to zero.
module next_hop_table_with_purge_top
    import nht_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      opcode,
    input  logic [ID_W-1:0] target_id,
    input  logic [ID_W-1:0] hop_in,
    output logic            result_valid,
    output logic            found,
    output logic [ID_W-1:0] hop_out,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [ID_W-1:0] cfg_data
);

    logic            queue_full;
    logic            queue_avail;
    logic            push;
    logic            pop;
    logic            sweeping;
    cmd_t            front_cmd;
    cmd_t            head_cmd;
    logic [ID_W-1:0] self_id_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            self_id_reg <= cfg_data;
        end
    end

    nht_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .start     (start),
        .queue_full(queue_full),
        .opcode    (opcode),
        .target_id (target_id),
        .hop_in    (hop_in),
        .busy      (busy),
        .push      (push),
        .cmd       (front_cmd)
    );

    nht_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(front_cmd),
        .pop     (pop),
        .full    (queue_full),
        .avail   (queue_avail),
        .head    (head_cmd)
    );

    nht_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .avail       (queue_avail),
        .head        (head_cmd),
        .self_id     (self_id_reg),
        .pop         (pop),
        .sweeping    (sweeping),
        .result_valid(result_valid),
        .found       (found),
        .hop_out     (hop_out)
    );

    a_miss_zero_hop: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (hop_out == '0))
        else $error("Lookup miss returned a nonzero hop.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("Busy rose without an accepted item.");

    a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweeping |-> !result_valid)
        else $error("Result issued during a purge sweep.");

    a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweeping |-> !pop)
        else $error("Queue popped during a purge sweep.");

endmodule
